// ----- src/swm_pkg.sv -----
// Shared types and constants for the star wildcard matcher.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package swm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int POS_W       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_STRING = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // What the pattern store shows to the position update logic.
  typedef struct packed {
    logic [MAX_PATTERN-1:0] star_mask;    // '*' at a filled position
    logic [MAX_PATTERN-1:0] lit_hit;      // literal equal to the compared byte
    logic [POS_W-1:0]       restart_set;  // start set after this request
    logic [LEN_W-1:0]       length;
    logic                   overflow;
  } pat_view_t;

endpackage
`default_nettype wire

// ----- src/swm_pattern.sv -----
// Pattern store: bytes, star mask, fill mask, length, overflow flag and the
// star-closed start set. Depends on swm_pkg.
`default_nettype none
module swm_pattern (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,      // request processed this cycle
  input  wire swm_pkg::mode_t      mode,
  input  wire logic [7:0]          data_byte,
  output swm_pkg::pat_view_t       view
);

  logic [7:0]                      store [swm_pkg::MAX_PATTERN];
  logic [swm_pkg::MAX_PATTERN-1:0] star_mask;
  logic [swm_pkg::MAX_PATTERN-1:0] fill_mask;
  logic [swm_pkg::LEN_W-1:0]       length;
  logic                            overflow;
  logic [swm_pkg::POS_W-1:0]       start_set;
  logic [swm_pkg::POS_W-1:0]       start_set_next;
  logic                            full;
  logic                            is_star;
  logic                            do_append;
  logic [swm_pkg::IDX_W-1:0]       wr_idx;

  assign full      = (length == swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN));
  assign is_star   = (data_byte == swm_pkg::STAR_BYTE);
  assign wr_idx    = length[swm_pkg::IDX_W-1:0];
  assign do_append = fire && (mode == swm_pkg::MODE_APPEND) && !full;

  // A new '*' extends the start set only when the start set already reaches it.
  always_comb begin
    start_set_next = start_set;
    if (mode == swm_pkg::MODE_CLEAR) begin
      start_set_next = swm_pkg::POS_W'(1);
    end else if (mode == swm_pkg::MODE_APPEND && !full) begin
      for (int i = 0; i < swm_pkg::MAX_PATTERN; i++) begin
        if (length == swm_pkg::LEN_W'(i) && start_set[i] && is_star) begin
          start_set_next[i+1] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      store[wr_idx]     <= data_byte;
      star_mask[wr_idx] <= is_star;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mask <= '0;
      length    <= '0;
      overflow  <= 1'b0;
      start_set <= swm_pkg::POS_W'(1);
    end else if (fire) begin
      if (mode == swm_pkg::MODE_CLEAR) begin
        fill_mask <= '0;
        length    <= '0;
        overflow  <= 1'b0;
      end else if (mode == swm_pkg::MODE_APPEND) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          fill_mask[wr_idx] <= 1'b1;
          length            <= length + swm_pkg::LEN_W'(1);
        end
      end
      start_set <= start_set_next;
    end
  end

  always_comb begin
    view.star_mask   = star_mask & fill_mask;
    for (int i = 0; i < swm_pkg::MAX_PATTERN; i++) begin
      view.lit_hit[i] = fill_mask[i] && !star_mask[i] && (store[i] == data_byte);
    end
    view.restart_set = start_set_next;
    view.length      = length;
    view.overflow    = overflow;
  end

endmodule
`default_nettype wire

// ----- src/swm_step.sv -----
// Position set update for one string byte, then closure over '*' runs.
// Depends on swm_pkg.
`default_nettype none
module swm_step (
  input  wire logic [swm_pkg::POS_W-1:0] active,
  input  wire swm_pkg::pat_view_t        view,
  output logic [swm_pkg::POS_W-1:0]      active_next
);

  logic [swm_pkg::POS_W-1:0] raw;
  logic [swm_pkg::POS_W-1:0] prop;
  logic [swm_pkg::POS_W-1:0] gen;
  logic [swm_pkg::POS_W-1:0] sum;
  logic [swm_pkg::POS_W-1:0] carry;

  // A star stays live; a matching literal moves on by one.
  assign raw = {1'b0, active[swm_pkg::MAX_PATTERN-1:0] & view.star_mask}
             | {active[swm_pkg::MAX_PATTERN-1:0] & view.lit_hit, 1'b0};

  // Closure as carry propagation: a live bit on a star ripples a carry through
  // the rest of the star run and into the position just past it.
  assign prop  = {1'b0, view.star_mask};
  assign gen   = {1'b0, raw[swm_pkg::MAX_PATTERN-1:0] & view.star_mask};
  assign sum   = prop + gen;
  assign carry = sum ^ prop ^ gen;

  assign active_next = raw | carry;

endmodule
`default_nettype wire

// ----- src/star_wildcard_matcher_top.sv -----
// Star-only glob matcher: top level with input register, position set and
// result register. Depends on swm_pkg, swm_pattern and swm_step.
// An accepted end-of-string request is held in the input register, then loads the result register.
// Throughput: one request per clock; input stalls only behind a held result.
// Reset (rst, synchronous): empty pattern, no overflow, position set {0}.
`default_nettype none
module star_wildcard_matcher_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic [1:0] s_tuser,   // [1:0] mode
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  // Input register
  logic                  in_v;
  swm_pkg::mode_t        in_mode;
  logic [7:0]            in_byte;

  // Set of reachable pattern positions, closed over '*'
  logic [swm_pkg::POS_W-1:0] active;
  logic [swm_pkg::POS_W-1:0] active_next;
  logic [swm_pkg::POS_W-1:0] step_set;

  swm_pkg::pat_view_t    view;
  logic                  advance;
  logic                  fire;
  logic                  out_free;

  // An end request needs a free result register; all others never wait.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = !in_v || (in_mode != swm_pkg::MODE_END) || out_free;
  assign fire     = in_v && advance;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (advance) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      in_mode <= swm_pkg::mode_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  swm_pattern u_pattern (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .mode      (in_mode),
    .data_byte (in_byte),
    .view      (view)
  );

  swm_step u_step (
    .active      (active),
    .view        (view),
    .active_next (step_set)
  );

  // String bytes advance the set; every other request restarts it.
  always_comb begin
    case (in_mode)
      swm_pkg::MODE_STRING: active_next = step_set;
      default:              active_next = view.restart_set;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= swm_pkg::POS_W'(1);
    end else if (fire) begin
      active <= active_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && in_mode == swm_pkg::MODE_END) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_mode == swm_pkg::MODE_END) begin
      m_tdata <= {6'b0, view.overflow, active[view.length]};
    end
  end

  // Checks
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && in_mode == swm_pkg::MODE_END |=> m_tvalid)
    else $error("end of string did not produce a result");

  a_clear_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && in_mode == swm_pkg::MODE_CLEAR |=> active == swm_pkg::POS_W'(1))
    else $error("position set not restarted by clear");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    view.length <= swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN))
    else $error("pattern length beyond store");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    view.overflow |-> view.length == swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN))
    else $error("overflow flagged with room left");

  a_stall_only_behind_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_v && in_mode == swm_pkg::MODE_END && m_tvalid && !m_tready)
    else $error("input stalled without a held result");

endmodule
`default_nettype wire
